// File: hdl/smie_pkg.sv
package smie_pkg;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int CALL_DEPTH_DEF  = 16;
  localparam int NUM_REGS_DEF    = 8;
  localparam int PC_BITS_DEF     = 16;
  localparam int OUT_PC_W        = 16;

  typedef enum logic [5:0] {
    OP_BEGIN = 6'd10, OP_POP = 6'd11, OP_ADD = 6'd12, OP_SUB = 6'd13,
    OP_MUL = 6'd14, OP_DIV = 6'd15, OP_OUT = 6'd16, OP_IN = 6'd17,
    OP_RET = 6'd18, OP_END = 6'd19, OP_CALL = 6'd20, OP_JMP = 6'd21,
    OP_JEQ = 6'd22, OP_JNE = 6'd23, OP_JA = 6'd24, OP_JAE = 6'd25,
    OP_JB = 6'd26, OP_JBE = 6'd27, OP_PUSH = 6'd30, OP_POPR = 6'd40,
    OP_PUSHR = 6'd41
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_SUNDER = 3'd1, ST_SOVER = 3'd2, ST_CUNDER = 3'd3,
    ST_COVER = 3'd4, ST_DIVZ = 3'd5, ST_BADOP = 3'd6, ST_BADARG = 3'd7
  } status_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

// File: hdl/smie_div.sv
module smie_div (
  input  logic              clk,
  input  logic              rst,
  input  smie_pkg::div_req_t req,
  output smie_pkg::div_rsp_t rsp
);
  import smie_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= 6'd32;
      rem   <= '0;
      quo   <= req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
      dvs   <= req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
      neg   <= req.dividend[31] ^ req.divisor[31];
    end else begin
      done <= busy && (count == 6'd1);
      if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) busy <= 1'b0;
      end
    end
  end

  assign rsp = {done, (neg ? (~quo + 32'd1) : quo)};
endmodule

// File: hdl/stack_machine_instruction_execute.sv
// Flow: the request is captured, its operands are read from the stack
// memories (registered read) and it is executed; DIV then waits for the
// radix-2 divider. One request at a time: in_stall is high until the result
// is taken (res_valid high while res_stall is low).
// Reset: rst (synchronous) clears depths, pc and the register file.
module stack_machine_instruction_execute #(
  parameter int STACK_DEPTH = smie_pkg::STACK_DEPTH_DEF,
  parameter int CALL_DEPTH  = smie_pkg::CALL_DEPTH_DEF,
  parameter int NUM_REGS    = smie_pkg::NUM_REGS_DEF,
  parameter int PC_BITS     = smie_pkg::PC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  operation,
  input  logic signed [31:0] argument,
  input  logic signed [31:0] in_value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] next_pc,
  output logic        out_valid,
  output logic signed [31:0] out_value,
  output logic [2:0]  status
);
  import smie_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int DA = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(CALL_DEPTH + 1);
  localparam int CA = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int RA = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_DONE} state_t;

  logic [31:0]        dmem [STACK_DEPTH];
  logic [PC_BITS-1:0] cmem [CALL_DEPTH];
  logic [31:0]        regs [NUM_REGS];

  state_t             state;
  logic [DW-1:0]      depth;
  logic [CW-1:0]      rdepth;
  logic [PC_BITS-1:0] pc;
  logic [5:0]         op;
  logic [31:0]        arg;
  logic [31:0]        inv;
  logic [31:0]        top;
  logic [31:0]        sec;
  logic [PC_BITS-1:0] ret_pc;
  logic [DA-1:0]      rd_a;
  logic [DA-1:0]      rd_b;
  logic [CA-1:0]      rd_c;
  logic               dwe;
  logic [DA-1:0]      dwa;
  logic [31:0]        dwd;
  logic               cwe;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic               arg_lbl_ok;
  logic               arg_reg_ok;
  logic               arg_zero;
  logic [PC_BITS-1:0] pc_inc;
  logic [PC_BITS-1:0] arg_pc;
  logic [RA-1:0]      ridx;
  logic               jmp_take;

  status_t            x_status;
  logic [PC_BITS-1:0] x_npc;
  logic [DW-1:0]      x_depth;
  logic [CW-1:0]      x_rdepth;
  logic               x_ov;
  logic [31:0]        x_oval;
  logic               x_dwe;
  logic [DA-1:0]      x_dwa;
  logic [31:0]        x_dwd;
  logic               x_cwe;
  logic               x_rwe;
  logic               x_div;

  assign in_stall = (state != S_IDLE);
  assign pc_inc   = pc + 1'b1;
  assign arg_pc   = arg[PC_BITS-1:0];
  assign ridx     = arg[RA-1:0];
  assign arg_zero = (arg == 32'd0);
  assign arg_lbl_ok = !arg[31] && ((PC_BITS >= 31) || ((arg >> PC_BITS) == 32'd0));
  assign arg_reg_ok = (arg < NUM_REGS);
  assign rd_a = DA'(depth - 1'b1);
  assign rd_b = DA'(depth - 2'd2);
  assign rd_c = CA'(rdepth - 1'b1);

  assign jmp_take = (op == OP_JEQ && top == sec) || (op == OP_JNE && top != sec) ||
                    (op == OP_JA && $signed(top) > $signed(sec)) ||
                    (op == OP_JAE && $signed(top) >= $signed(sec)) ||
                    (op == OP_JB && $signed(top) < $signed(sec)) ||
                    (op == OP_JBE && $signed(top) <= $signed(sec));

  always_comb begin
    x_status = ST_OK;
    x_npc    = pc_inc;
    x_depth  = depth;
    x_rdepth = rdepth;
    x_ov     = 1'b0;
    x_oval   = '0;
    x_dwe    = 1'b0;
    x_dwa    = DA'(depth);
    x_dwd    = '0;
    x_cwe    = 1'b0;
    x_rwe    = 1'b0;
    x_div    = 1'b0;
    if (op >= OP_BEGIN && op <= OP_END && !arg_zero) x_status = ST_BADARG;
    else if (op >= OP_CALL && op <= OP_JBE && !arg_lbl_ok) x_status = ST_BADARG;
    else begin
      unique case (op)
        OP_BEGIN: x_npc = pc_inc;
        OP_POP: begin
          if (depth == '0) x_status = ST_SUNDER;
          else x_depth = depth - 1'b1;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          if (depth < DW'(2)) x_status = ST_SUNDER;
          else begin
            x_dwe = 1'b1;
            x_dwa = rd_b;
            if (op == OP_ADD) x_dwd = top + sec;
            else if (op == OP_SUB) x_dwd = top - sec;
            else x_dwd = 32'(top * sec);
            x_depth = depth - 1'b1;
          end
        end
        OP_DIV: begin
          if (depth < DW'(2)) x_status = ST_SUNDER;
          else if (sec == 32'd0) x_status = ST_DIVZ;
          else x_div = 1'b1;
        end
        OP_OUT: begin
          if (depth == '0) x_status = ST_SUNDER;
          else begin
            x_ov    = 1'b1;
            x_oval  = top;
            x_depth = depth - 1'b1;
          end
        end
        OP_IN, OP_PUSH: begin
          if (depth >= DW'(STACK_DEPTH)) x_status = ST_SOVER;
          else begin
            x_dwe   = 1'b1;
            x_dwd   = (op == OP_IN) ? inv : arg;
            x_depth = depth + 1'b1;
          end
        end
        OP_RET: begin
          if (rdepth == '0) x_status = ST_CUNDER;
          else begin
            x_rdepth = rdepth - 1'b1;
            x_npc    = ret_pc + 1'b1;
          end
        end
        OP_END: x_npc = '0;
        OP_CALL: begin
          if (rdepth >= CW'(CALL_DEPTH)) x_status = ST_COVER;
          else begin
            x_cwe    = 1'b1;
            x_rdepth = rdepth + 1'b1;
            x_npc    = arg_pc;
          end
        end
        OP_JMP: x_npc = arg_pc;
        OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
          if (depth < DW'(2)) x_status = ST_SUNDER;
          else begin
            x_depth = depth - 2'd2;
            if (jmp_take) x_npc = arg_pc;
          end
        end
        OP_POPR: begin
          if (!arg_reg_ok) x_status = ST_BADARG;
          else if (depth == '0) x_status = ST_SUNDER;
          else begin
            x_rwe   = 1'b1;
            x_depth = depth - 1'b1;
          end
        end
        OP_PUSHR: begin
          if (!arg_reg_ok) x_status = ST_BADARG;
          else if (depth >= DW'(STACK_DEPTH)) x_status = ST_SOVER;
          else begin
            x_dwe   = 1'b1;
            x_dwd   = regs[ridx];
            x_depth = depth + 1'b1;
          end
        end
        default: x_status = ST_BADOP;
      endcase
    end
    if (x_status != ST_OK) x_npc = pc;
  end

  assign dwe  = ((state == S_EXEC) && x_dwe) || ((state == S_DIV) && drsp.done);
  assign dwa  = (state == S_DIV) ? rd_b : x_dwa;
  assign dwd  = (state == S_DIV) ? drsp.quotient : x_dwd;
  assign cwe  = (state == S_EXEC) && x_cwe;
  assign dreq = {((state == S_EXEC) && x_div), top, sec};

  always_ff @(posedge clk) begin
    top    <= dmem[rd_a];
    sec    <= dmem[rd_b];
    ret_pc <= cmem[rd_c];
    if (dwe) dmem[dwa] <= dwd;
    if (cwe) cmem[CA'(rdepth)] <= pc;
  end

  smie_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      rdepth    <= '0;
      pc        <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= operation;
            arg   <= argument;
            inv   <= in_value;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          next_pc   <= 16'(x_npc);
          out_valid <= x_ov;
          out_value <= x_oval;
          status    <= x_status;
          if (x_rwe) regs[ridx] <= top;
          if (x_div) state <= S_DIV;
          else begin
            pc        <= x_npc;
            depth     <= x_depth;
            rdepth    <= x_rdepth;
            res_valid <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            depth     <= depth - 1'b1;
            pc        <= pc_inc;
            res_valid <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH)) else $error("data depth out of range");
  a_call_range: assert property (@(posedge clk) disable iff (rst)
    rdepth <= CW'(CALL_DEPTH)) else $error("call depth out of range");
  a_res_state: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == S_DONE) else $error("result outside done state");
  a_fault_pc: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) ##1 (status != ST_OK) |-> $stable(pc))
    else $error("fault changed pc");
endmodule
